// File: design/rmj_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the radar measurement Jacobian pipeline.
// Used by the divider, square root and top level files; depends on nothing.
package rmj_pkg;

	// Quotient bits resolved per register stage in each divider.
	localparam int DIV_STEPS = 4;
	// Root bits resolved per register stage in the square root unit.
	localparam int SQRT_STEPS = 4;
	// Register stages between the direction dividers and the gradient dividers.
	localparam int RATE_STAGES = 4;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: design/rmj_delay.sv
`timescale 1ns / 1ps
// Enabled delay line that carries side data alongside the arithmetic units.
// Stand-alone; no package needed.
module rmj_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	// Shift every tap by one place when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

// File: design/rmj_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root of a normalized range squared.
// Uses rmj_pkg for the number of root bits per stage.
module rmj_sqrt #(
	parameter int RN_BITS = 32
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2*RN_BITS-1:0]   n,
	output logic [RN_BITS-1:0]     root
);

	import rmj_pkg::*;

	localparam int RN = RN_BITS;
	localparam int NW = 2 * RN_BITS;
	localparam int NS = (RN + SQRT_STEPS - 1) / SQRT_STEPS;

	logic [RN:0]   rem_s  [1:NS];
	logic [RN-1:0] root_s [1:NS];
	logic [NW-1:0] n_s    [1:NS];

	for (genvar s = 0; s < NS; s++) begin : g_st
		logic [RN:0]   r_i, r_c;
		logic [RN-1:0] t_i, t_c;
		logic [NW-1:0] n_i, n_c;
		logic [RN+2:0] cur, trial;

		if (s == 0) begin : g_first
			assign r_i = '0;
			assign t_i = '0;
			assign n_i = n;
		end else begin : g_next
			assign r_i = rem_s[s];
			assign t_i = root_s[s];
			assign n_i = n_s[s];
		end

		// Each step brings down two radicand bits and tries one more root bit.
		always_comb begin
			r_c   = r_i;
			t_c   = t_i;
			n_c   = n_i;
			cur   = '0;
			trial = '0;
			for (int j = 0; j < SQRT_STEPS; j++) begin
				if (s * SQRT_STEPS + j < RN) begin
					cur   = {r_c, n_c[NW-1:NW-2]};
					trial = (RN+3)'({t_c, 2'b01});
					n_c   = n_c << 2;
					if (cur >= trial) begin
						r_c = (RN+1)'(cur - trial);
						t_c = {t_c[RN-2:0], 1'b1};
					end else begin
						r_c = cur[RN:0];
						t_c = {t_c[RN-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1]  <= r_c;
				root_s[s+1] <= t_c;
				n_s[s+1]    <= n_c;
			end
		end
	end

	assign root = root_s[NS];

endmodule

// File: design/rmj_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: round((num << sh) / den), saturated and signed.
// Uses rmj_pkg for the bits per stage; den must have its top bit set.
module rmj_div #(
	parameter int WORD_BITS = 32,
	parameter int RN_BITS   = 32,
	parameter int NUM_W     = 32,
	parameter int SH_MAX    = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [NUM_W-1:0]              num,
	input  logic [$clog2(SH_MAX+1)-1:0]   sh,
	input  logic [RN_BITS-1:0]            den,
	input  logic                          neg,
	output logic [WORD_BITS-1:0]          mag,
	output logic signed [WORD_BITS-1:0]   val
);

	import rmj_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int RN  = RN_BITS;
	localparam int QB  = W + 1;
	localparam int XW  = imax(NUM_W + SH_MAX + 1, QB + 1);
	localparam int HIW = XW - QB;
	localparam int CW  = imax(HIW, RN);
	localparam int NS  = (QB + DIV_STEPS - 1) / DIV_STEPS;

	logic [RN-1:0] rem_s [0:NS];
	logic [QB-1:0] q_s   [0:NS];
	logic [QB-1:0] lo_s  [0:NS];
	logic [RN-1:0] den_s [0:NS];
	logic          ovf_s [0:NS];
	logic          neg_s [0:NS];

	logic [XW-1:0] x_c;
	logic [CW-1:0] hi_c, dn_c;
	logic          ovf_c;

	// Doubled numerator; the part above the quotient field decides overflow.
	always_comb begin
		x_c   = (XW'(num) << sh) << 1;
		hi_c  = CW'(x_c >> QB);
		dn_c  = CW'(den);
		ovf_c = (hi_c >= dn_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf_c ? '0 : hi_c[RN-1:0];
			q_s[0]   <= '0;
			lo_s[0]  <= x_c[QB-1:0];
			den_s[0] <= den;
			ovf_s[0] <= ovf_c;
			neg_s[0] <= neg;
		end
	end

	for (genvar s = 0; s < NS; s++) begin : g_st
		logic [RN-1:0] r_c;
		logic [QB-1:0] q_c, l_c;
		logic [RN:0]   cur;

		// Each step brings down one bit and resolves one quotient bit.
		always_comb begin
			r_c = rem_s[s];
			q_c = q_s[s];
			l_c = lo_s[s];
			cur = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (s * DIV_STEPS + j < QB) begin
					cur = {r_c, l_c[QB-1]};
					l_c = {l_c[QB-2:0], 1'b0};
					if (cur >= {1'b0, den_s[s]}) begin
						r_c = cur[RN-1:0] - den_s[s];
						q_c = {q_c[QB-2:0], 1'b1};
					end else begin
						r_c = cur[RN-1:0];
						q_c = {q_c[QB-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1] <= r_c;
				q_s[s+1]   <= q_c;
				lo_s[s+1]  <= l_c;
				den_s[s+1] <= den_s[s];
				ovf_s[s+1] <= ovf_s[s];
				neg_s[s+1] <= neg_s[s];
			end
		end
	end

	logic [QB-1:0] rnd_c, lim_c, m_c;

	// Round half up from the doubled quotient, then clamp to the signed range.
	always_comb begin
		rnd_c = QB'(({1'b0, q_s[NS]} + (QB+1)'(1)) >> 1);
		lim_c = neg_s[NS] ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - QB'(1));
		m_c   = (ovf_s[NS] || (rnd_c > lim_c)) ? lim_c : rnd_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= m_c[W-1:0];
			val <= neg_s[NS] ? -$signed(m_c[W-1:0]) : $signed(m_c[W-1:0]);
		end
	end

endmodule

// File: design/radar_measurement_jacobian.sv
`timescale 1ns / 1ps
// Radar measurement Jacobian: five entry stages, the range root, two chained dividers,
// four rate stages and an output register; one item per cycle unless a result is stalled.
// At the default widths the root has 8 stages and 32 bits and each divider 11 stages.
// A stalled result freezes the whole pipeline in place; nothing is lost or repeated.
// Asynchronous active-low reset clears every valid bit; data registers are not reset.
// Depends on rmj_pkg, rmj_delay, rmj_sqrt and rmj_div.
module radar_measurement_jacobian #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] pos_x,
	input  logic signed [WORD_BITS-1:0] pos_y,
	input  logic signed [WORD_BITS-1:0] vel_x,
	input  logic signed [WORD_BITS-1:0] vel_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] range_dir_x,
	output logic signed [WORD_BITS-1:0] range_dir_y,
	output logic signed [WORD_BITS-1:0] bearing_grad_x,
	output logic signed [WORD_BITS-1:0] bearing_grad_y,
	output logic signed [WORD_BITS-1:0] rate_grad_x,
	output logic signed [WORD_BITS-1:0] rate_grad_y,
	output logic                        zero_range
);

	import rmj_pkg::*;

	localparam int W      = WORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int RN     = (W > 32) ? W : 32;
	localparam int NW     = 2 * RN;
	localparam int HW     = $clog2(RN);
	localparam int HS     = HW / 2;
	localparam int DM     = (F + 1 < W) ? F + 1 : W;
	localparam int WW     = W + DM + 2;
	localparam int W1W    = WW + 1 - F;
	localparam int TW     = W1W + DM;
	localparam int FSH_W  = $clog2(F + 1);
	localparam int BSH_W  = $clog2(F + RN);
	localparam int SQ_LAT = (RN + SQRT_STEPS - 1) / SQRT_STEPS;
	localparam int DV_LAT = (W + 1 + DIV_STEPS - 1) / DIV_STEPS + 2;
	localparam int LAT    = 5 + SQ_LAT + DV_LAT + RATE_STAGES + DV_LAT + 1;
	localparam int D1W    = 2 * RN + HW + 3 + 2 * W;
	localparam int D2W    = RN + HW + 3 + 2 * W;
	localparam int D3W    = 1 + 2 * W;

	logic           en;
	logic [LAT-1:0] vld_q;

	// The pipeline moves unless a finished result is being held.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = out_valid && out_stall;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: magnitudes and signs of the position.
	logic [W-1:0]        ap_s1, aq_s1;
	logic                sp_s1, sq_s1, zr_s1;
	logic signed [W-1:0] u_s1, v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s1 <= pos_x[W-1] ? W'(-pos_x) : W'(pos_x);
			aq_s1 <= pos_y[W-1] ? W'(-pos_y) : W'(pos_y);
			sp_s1 <= pos_x[W-1];
			sq_s1 <= pos_y[W-1];
			zr_s1 <= (pos_x == '0) && (pos_y == '0);
			u_s1  <= vel_x;
			v_s1  <= vel_y;
		end
	end

	// Stages 2 and 3: squares, then their sum.
	logic [2*W-1:0]      pp_s2, qq_s2, r2_s3;
	logic [W-1:0]        ap_s2, aq_s2, ap_s3, aq_s3;
	logic                sp_s2, sq_s2, zr_s2, sp_s3, sq_s3, zr_s3;
	logic signed [W-1:0] u_s2, v_s2, u_s3, v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s2 <= (2*W)'(ap_s1) * (2*W)'(ap_s1);
			qq_s2 <= (2*W)'(aq_s1) * (2*W)'(aq_s1);
			ap_s2 <= ap_s1;
			aq_s2 <= aq_s1;
			sp_s2 <= sp_s1;
			sq_s2 <= sq_s1;
			zr_s2 <= zr_s1;
			u_s2  <= u_s1;
			v_s2  <= v_s1;
			r2_s3 <= pp_s2 + qq_s2;
			ap_s3 <= ap_s2;
			aq_s3 <= aq_s2;
			sp_s3 <= sp_s2;
			sq_s3 <= sq_s2;
			zr_s3 <= zr_s2;
			u_s3  <= u_s2;
			v_s3  <= v_s2;
		end
	end

	// Stages 4 and 5: shift the sum left by bit pairs until its top pair is nonzero.
	logic [NW-1:0]       n4_c, n5_c, n_s4, n_s5;
	logic [HW-1:0]       h4_c, h5_c, h_s4, h_s5;
	logic [W-1:0]        ap_s4, aq_s4, ap_s5, aq_s5;
	logic                sp_s4, sq_s4, zr_s4, sp_s5, sq_s5, zr_s5;
	logic signed [W-1:0] u_s4, v_s4, u_s5, v_s5;

	always_comb begin
		n4_c = NW'(r2_s3);
		h4_c = '0;
		for (int b = HW - 1; b >= HS; b--) begin
			if ((n4_c >> (NW - (2 << b))) == '0) begin
				n4_c    = n4_c << (2 << b);
				h4_c[b] = 1'b1;
			end
		end
	end

	always_comb begin
		n5_c = n_s4;
		h5_c = h_s4;
		for (int b = HS - 1; b >= 0; b--) begin
			if ((n5_c >> (NW - (2 << b))) == '0) begin
				n5_c    = n5_c << (2 << b);
				h5_c[b] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4  <= n4_c;
			h_s4  <= h4_c;
			ap_s4 <= ap_s3;
			aq_s4 <= aq_s3;
			sp_s4 <= sp_s3;
			sq_s4 <= sq_s3;
			zr_s4 <= zr_s3;
			u_s4  <= u_s3;
			v_s4  <= v_s3;
			n_s5  <= n5_c;
			h_s5  <= h5_c;
			ap_s5 <= ap_s4;
			aq_s5 <= aq_s4;
			sp_s5 <= sp_s4;
			sq_s5 <= sq_s4;
			zr_s5 <= zr_s4;
			u_s5  <= u_s4;
			v_s5  <= v_s4;
		end
	end

	// Range root, with the scaled position magnitudes waiting beside it.
	logic [RN-1:0]       root, a_d1, b_d1;
	logic [HW-1:0]       h_d1;
	logic                sp_d1, sq_d1, zr_d1;
	logic signed [W-1:0] u_d1, v_d1;
	logic [D1W-1:0]      d1_q;

	rmj_sqrt #(.RN_BITS(RN)) u_sqrt (
		.clk (clk),
		.en  (en),
		.n   (n_s5),
		.root(root)
	);

	rmj_delay #(.WIDTH(D1W), .DEPTH(SQ_LAT)) u_dly_root (
		.clk(clk),
		.en (en),
		.d  ({RN'(ap_s5) << h_s5, RN'(aq_s5) << h_s5, h_s5, sp_s5, sq_s5, zr_s5,
			u_s5, v_s5}),
		.q  (d1_q)
	);

	assign {a_d1, b_d1, h_d1, sp_d1, sq_d1, zr_d1, u_d1, v_d1} = d1_q;

	// Direction cosines px/r and py/r.
	logic [W-1:0]        dx_mag, dy_mag;
	logic signed [W-1:0] dx_val, dy_val;

	rmj_div #(.WORD_BITS(W), .RN_BITS(RN), .NUM_W(RN), .SH_MAX(F)) u_div_dx (
		.clk(clk), .en(en), .num(a_d1), .sh(FSH_W'(F)), .den(root), .neg(sp_d1),
		.mag(dx_mag), .val(dx_val)
	);

	rmj_div #(.WORD_BITS(W), .RN_BITS(RN), .NUM_W(RN), .SH_MAX(F)) u_div_dy (
		.clk(clk), .en(en), .num(b_d1), .sh(FSH_W'(F)), .den(root), .neg(sq_d1),
		.mag(dy_mag), .val(dy_val)
	);

	logic [RN-1:0]       rn_d2;
	logic [HW-1:0]       h_d2;
	logic                sp_d2, sq_d2, zr_d2;
	logic signed [W-1:0] u_d2, v_d2;
	logic [D2W-1:0]      d2_q;

	rmj_delay #(.WIDTH(D2W), .DEPTH(DV_LAT)) u_dly_dir (
		.clk(clk),
		.en (en),
		.d  ({root, h_d1, sp_d1, sq_d1, zr_d1, u_d1, v_d1}),
		.q  (d2_q)
	);

	assign {rn_d2, h_d2, sp_d2, sq_d2, zr_d2, u_d2, v_d2} = d2_q;

	// Stage 6: cross products of velocity with the signed directions.
	logic [DM-1:0]        dxm_c, dym_c;
	logic signed [DM:0]   dx_sg_c, dy_sg_c;
	logic signed [WW-2:0] pu_s6, pv_s6;
	logic signed [WW-1:0] w_s7;
	logic [W1W-1:0]       w1m_s8;
	logic                 ws_s8;
	logic [WW:0]          wr_c;
	logic [TW-1:0]        txm_s9, tym_s9;
	logic                 negx_s9, negy_s9;

	always_comb begin
		dxm_c   = dx_mag[DM-1:0];
		dym_c   = dy_mag[DM-1:0];
		dx_sg_c = sp_d2 ? -$signed({1'b0, dxm_c}) : $signed({1'b0, dxm_c});
		dy_sg_c = sq_d2 ? -$signed({1'b0, dym_c}) : $signed({1'b0, dym_c});
	end

	// Stage 8 rounding: magnitude plus one half, done as a single add.
	localparam logic [WW:0] HALF0 = (WW+1)'(1) << (F - 1);
	localparam logic [WW:0] HALF1 = HALF0 + (WW+1)'(1);

	always_comb begin
		if (w_s7[WW-1]) begin
			wr_c = (WW+1)'($unsigned(~w_s7)) + HALF1;
		end else begin
			wr_c = (WW+1)'($unsigned(w_s7)) + HALF0;
		end
	end

	// Side data through the four rate stages.
	logic [RN-1:0]       rn_s6, rn_s7, rn_s8, rn_s9;
	logic [HW-1:0]       h_s6, h_s7, h_s8, h_s9;
	logic                sp_s6, sp_s7, sp_s8, sp_s9;
	logic                sq_s6, sq_s7, sq_s8, sq_s9;
	logic                zr_s6, zr_s7, zr_s8, zr_s9;
	logic [DM-1:0]       dxm_s6, dxm_s7, dxm_s8, dxm_s9;
	logic [DM-1:0]       dym_s6, dym_s7, dym_s8, dym_s9;
	logic signed [W-1:0] dxv_s6, dxv_s7, dxv_s8, dxv_s9;
	logic signed [W-1:0] dyv_s6, dyv_s7, dyv_s8, dyv_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s6   <= u_d2 * dy_sg_c;
			pv_s6   <= v_d2 * dx_sg_c;
			w_s7    <= WW'(pu_s6) - WW'(pv_s6);
			w1m_s8  <= W1W'(wr_c >> F);
			ws_s8   <= w_s7[WW-1];
			txm_s9  <= TW'(w1m_s8) * TW'(dym_s8);
			tym_s9  <= TW'(w1m_s8) * TW'(dxm_s8);
			negx_s9 <= ws_s8 ^ sq_s8;
			negy_s9 <= ~(ws_s8 ^ sp_s8);

			rn_s6  <= rn_d2;   rn_s7  <= rn_s6;   rn_s8  <= rn_s7;   rn_s9  <= rn_s8;
			h_s6   <= h_d2;    h_s7   <= h_s6;    h_s8   <= h_s7;    h_s9   <= h_s8;
			sp_s6  <= sp_d2;   sp_s7  <= sp_s6;   sp_s8  <= sp_s7;   sp_s9  <= sp_s8;
			sq_s6  <= sq_d2;   sq_s7  <= sq_s6;   sq_s8  <= sq_s7;   sq_s9  <= sq_s8;
			zr_s6  <= zr_d2;   zr_s7  <= zr_s6;   zr_s8  <= zr_s7;   zr_s9  <= zr_s8;
			dxm_s6 <= dxm_c;   dxm_s7 <= dxm_s6;  dxm_s8 <= dxm_s7;  dxm_s9 <= dxm_s8;
			dym_s6 <= dym_c;   dym_s7 <= dym_s6;  dym_s8 <= dym_s7;  dym_s9 <= dym_s8;
			dxv_s6 <= dx_val;  dxv_s7 <= dxv_s6;  dxv_s8 <= dxv_s7;  dxv_s9 <= dxv_s8;
			dyv_s6 <= dy_val;  dyv_s7 <= dyv_s6;  dyv_s8 <= dyv_s7;  dyv_s9 <= dyv_s8;
		end
	end

	// Bearing and range-rate gradients, four dividers side by side.
	logic signed [W-1:0] bx_val, by_val, rx_val, ry_val;

	rmj_div #(.WORD_BITS(W), .RN_BITS(RN), .NUM_W(DM), .SH_MAX(F + RN - 1)) u_div_bx (
		.clk(clk), .en(en), .num(dym_s9), .sh(BSH_W'(F) + BSH_W'(h_s9)), .den(rn_s9),
		.neg(~sq_s9), .mag(), .val(bx_val)
	);

	rmj_div #(.WORD_BITS(W), .RN_BITS(RN), .NUM_W(DM), .SH_MAX(F + RN - 1)) u_div_by (
		.clk(clk), .en(en), .num(dxm_s9), .sh(BSH_W'(F) + BSH_W'(h_s9)), .den(rn_s9),
		.neg(sp_s9), .mag(), .val(by_val)
	);

	rmj_div #(.WORD_BITS(W), .RN_BITS(RN), .NUM_W(TW), .SH_MAX(RN - 1)) u_div_rx (
		.clk(clk), .en(en), .num(txm_s9), .sh(h_s9), .den(rn_s9),
		.neg(negx_s9), .mag(), .val(rx_val)
	);

	rmj_div #(.WORD_BITS(W), .RN_BITS(RN), .NUM_W(TW), .SH_MAX(RN - 1)) u_div_ry (
		.clk(clk), .en(en), .num(tym_s9), .sh(h_s9), .den(rn_s9),
		.neg(negy_s9), .mag(), .val(ry_val)
	);

	logic                zr_d3;
	logic signed [W-1:0] dxv_d3, dyv_d3;
	logic [D3W-1:0]      d3_q;

	rmj_delay #(.WIDTH(D3W), .DEPTH(DV_LAT)) u_dly_grad (
		.clk(clk),
		.en (en),
		.d  ({zr_s9, dxv_s9, dyv_s9}),
		.q  (d3_q)
	);

	assign {zr_d3, dxv_d3, dyv_d3} = d3_q;

	// Output register: a zero range forces every value field to zero.
	logic signed [W-1:0] rdx_q, rdy_q, bgx_q, bgy_q, rgx_q, rgy_q;
	logic                zr_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdx_q <= zr_d3 ? '0 : dxv_d3;
			rdy_q <= zr_d3 ? '0 : dyv_d3;
			bgx_q <= zr_d3 ? '0 : bx_val;
			bgy_q <= zr_d3 ? '0 : by_val;
			rgx_q <= zr_d3 ? '0 : rx_val;
			rgy_q <= zr_d3 ? '0 : ry_val;
			zr_q  <= zr_d3;
		end
	end

	assign range_dir_x    = rdx_q;
	assign range_dir_y    = rdy_q;
	assign bearing_grad_x = bgx_q;
	assign bearing_grad_y = bgy_q;
	assign rate_grad_x    = rgx_q;
	assign rate_grad_y    = rgy_q;
	assign zero_range     = zr_q;

	// Direction cosines never exceed one in magnitude.
	localparam logic signed [W:0] ONE = (W+1)'(1) << F;

	a_zero_clears : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_range |-> range_dir_x == '0 && range_dir_y == '0 &&
		bearing_grad_x == '0 && bearing_grad_y == '0 &&
		rate_grad_x == '0 && rate_grad_y == '0)
		else $error("zero range result carries nonzero values");

	a_stall_src : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_freeze : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_dir_bound : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_range |-> $signed(range_dir_x) <= ONE &&
		$signed(range_dir_x) >= -ONE && $signed(range_dir_y) <= ONE &&
		$signed(range_dir_y) >= -ONE)
		else $error("direction cosine out of range");

endmodule

// File: tb/sv/radar_measurement_jacobian_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the radar measurement Jacobian pipeline.
// Drives random and corner-case states, predicts each Jacobian in exact integer math.
// Depends on radar_measurement_jacobian (and through it on rmj_pkg).
module radar_measurement_jacobian_tb;

	localparam int W = 32;
	localparam int F = 16;
	localparam longint unsigned HALFW = 64'd1 << (W - 1);
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [W-1:0] px;
		logic signed [W-1:0] py;
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
	} track_state_t;

	typedef struct packed {
		logic signed [W-1:0] dir_x;
		logic signed [W-1:0] dir_y;
		logic signed [W-1:0] brg_x;
		logic signed [W-1:0] brg_y;
		logic signed [W-1:0] rate_x;
		logic signed [W-1:0] rate_y;
		logic                zero;
	} jacobian_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [W-1:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [W-1:0] range_dir_x, range_dir_y, bearing_grad_x, bearing_grad_y;
	logic signed [W-1:0] rate_grad_x, rate_grad_y;
	logic zero_range;

	track_state_t pending_states[$];
	jacobian_t expected_jacobians[$];
	int errors = 0;
	int cycles = 0;
	bit stimulus_done = 1'b0;

	radar_measurement_jacobian uut (.*);

	// Clock generator.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Exact integer square root of a 64-bit value.
	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Rounded quotient of (num << sh) / den, clamped to lim.
	function automatic longint unsigned scaled_quotient(input longint unsigned num,
			input int sh, input longint unsigned den, input longint unsigned lim);
		logic [127:0] wide, q;
		wide = {64'd0, num} << sh;
		q = wide / den;
		if ((wide % den) * 2 >= den) q++;
		return (q > lim) ? lim : q[63:0];
	endfunction

	// Signed result from sign and magnitude, saturated to the word range.
	function automatic logic [W-1:0] signed_sat(input bit neg, input longint unsigned num,
			input int sh, input longint unsigned den);
		longint unsigned m;
		m = scaled_quotient(num, sh, den, neg ? HALFW : HALFW - 1);
		return neg ? W'(-m) : W'(m);
	endfunction

	// Predicts the Jacobian entries for one track state.
	function automatic jacobian_t compute_jacobian(input track_state_t s);
		jacobian_t j;
		longint p, q, u, v, dx, dy, w, w1, tx, ty;
		longint unsigned ap, aq, n, rn, dxm, dym, w1m;
		int h;
		j = '0;
		p = s.px; q = s.py; u = s.vx; v = s.vy;
		if (p == 0 && q == 0) begin
			j.zero = 1'b1;
			return j;
		end
		ap = (p < 0) ? -p : p;
		aq = (q < 0) ? -q : q;
		n = ap * ap + aq * aq;
		h = 0;
		while ((n >> 62) == 0) begin
			n <<= 2;
			h++;
		end
		rn = int_sqrt(n);
		dxm = scaled_quotient(ap << h, F, rn, HALFW);
		dym = scaled_quotient(aq << h, F, rn, HALFW);
		dx = (p < 0) ? -longint'(dxm) : longint'(dxm);
		dy = (q < 0) ? -longint'(dym) : longint'(dym);
		j.dir_x = (p < 0) ? W'(-dxm) : W'(dxm);
		j.dir_y = (q < 0) ? W'(-dym) : W'(dym);
		j.brg_x = signed_sat(q > 0, dym, F + h, rn);
		j.brg_y = signed_sat(p < 0, dxm, F + h, rn);
		w = u * dy - v * dx;
		w1m = (((w < 0) ? -w : w) + (64'd1 << (F - 1))) >> F;
		w1 = (w < 0) ? -longint'(w1m) : longint'(w1m);
		tx = w1 * dy;
		ty = -(w1 * dx);
		j.rate_x = signed_sat(tx < 0, (tx < 0) ? -tx : tx, h, rn);
		j.rate_y = signed_sat(ty < 0, (ty < 0) ? -ty : ty, h, rn);
		return j;
	endfunction

	// Random word with a random magnitude class so small and huge values both appear.
	function automatic logic [W-1:0] random_word();
		logic [W-1:0] r;
		int sh;
		r = $urandom;
		sh = $urandom_range(0, W - 1);
		case ($urandom_range(0, 3))
			0: return r;
			1: return $signed(r) >>> sh;
			2: return W'($urandom_range(0, 8)) - W'(4);
			default: return (r[0] ? 32'sh7fff_ffff : 32'sh8000_0000) ^ (r >> sh);
		endcase
	endfunction

	// Fills the queue of states: corner cases first, then random ones; then releases reset.
	initial begin
		logic [W-1:0] corners[8];
		corners = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h0001_0000, 32'hffff_0000, 32'h0000_0003};
		for (int i = 0; i < 8; i++)
			pending_states.push_back('{corners[i], corners[7 - i],
				corners[(i + 3) % 8], corners[(i + 5) % 8]});
		pending_states.push_back('{32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000});
		pending_states.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
		pending_states.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
		pending_states.push_back('{32'h0, 32'h1, 32'h7fff_ffff, 32'h7fff_ffff});
		pending_states.push_back('{32'h1, 32'h0, 32'h8000_0000, 32'h8000_0000});
		pending_states.push_back('{32'hffff_ffff, 32'h1, 32'h0, 32'h0});
		pending_states.push_back('{32'h0, 32'h0, 32'h0, 32'h0});
		for (int i = 0; i < 1850; i++)
			pending_states.push_back('{random_word(), random_word(),
				random_word(), random_word()});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: bursts of items separated by random gaps.
	// The head of the queue is the item on the bus until it is accepted.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_jacobians.push_back(compute_jacobian({pos_x, pos_y, vel_x, vel_y}));
				void'(pending_states.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_states.size() > 0) begin
					track_state_t nxt;
					nxt = pending_states[0];
					in_valid <= 1'b1;
					{pos_x, pos_y, vel_x, vel_y} <= nxt;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
		end
	end

	// Receiver stall pattern: phases of no stalls, light stalls and heavy stalls.
	always @(posedge clk) begin
		case ((cycles / 700) % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 2) != 0);
		endcase
	end

	// Monitor: compares each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_jacobians.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				jacobian_t e;
				e = expected_jacobians.pop_front();
				if (range_dir_x !== e.dir_x) begin
					$error("range_dir_x exp %0d got %0d", e.dir_x, range_dir_x); errors++;
				end
				if (range_dir_y !== e.dir_y) begin
					$error("range_dir_y exp %0d got %0d", e.dir_y, range_dir_y); errors++;
				end
				if (bearing_grad_x !== e.brg_x) begin
					$error("bearing_grad_x exp %0d got %0d", e.brg_x, bearing_grad_x); errors++;
				end
				if (bearing_grad_y !== e.brg_y) begin
					$error("bearing_grad_y exp %0d got %0d", e.brg_y, bearing_grad_y); errors++;
				end
				if (rate_grad_x !== e.rate_x) begin
					$error("rate_grad_x exp %0d got %0d", e.rate_x, rate_grad_x); errors++;
				end
				if (rate_grad_y !== e.rate_y) begin
					$error("rate_grad_y exp %0d got %0d", e.rate_y, rate_grad_y); errors++;
				end
				if (zero_range !== e.zero) begin
					$error("zero_range exp %0d got %0d", e.zero, zero_range); errors++;
				end
			end
		end
	end

	// End of run: drain, wait out the pipeline latency, then report; or time out.
	initial begin
		int drain;
		drain = 0;
		while (!(stimulus_done && expected_jacobians.size() == 0) && cycles < CYCLE_LIMIT)
			@(posedge clk);
		while (drain < 100 && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
		end else if (errors == 0 && expected_jacobians.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Cycle counter for the run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

endmodule
